// File: src/dltq_pkg.sv
// Package for the delta list timer queue: sizes, status and request codes,
// cell types and the control state encoding. No dependencies.
package dltq_pkg;

  localparam int unsigned ENTRIES = 16;
  localparam int unsigned IdW     = 4;
  localparam int unsigned PosW    = $clog2(ENTRIES + 1);
  localparam int unsigned DeltaW  = 32;

  typedef enum logic [1:0] {
    REQ_SCHEDULE = 2'd0,
    REQ_TICK     = 2'd1,
    REQ_CANCEL   = 2'd2,
    REQ_NONE     = 2'd3
  } req_type_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_ZERO_DELAY  = 3'd1,
    ST_FULL        = 3'd2,
    ST_BAD_ID      = 3'd3,
    ST_NOT_WAITING = 3'd4,
    ST_NO_EXPIRY   = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_SUB,
    OP_ADD,
    OP_LOAD,
    OP_TAKE_LEFT,
    OP_TAKE_RIGHT
  } cell_op_e;

  typedef struct packed {
    logic              valid;
    logic [IdW-1:0]    id;
    logic [DeltaW-1:0] delta;
  } cell_t;

  typedef struct packed {
    logic [2:0]     status;
    logic [IdW-1:0] id;
    logic           expired;
    logic           last;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_SCAN,
    S_INS_SHIFT,
    S_INS_FIX,
    S_TICK_CHK,
    S_TICK_POP,
    S_CAN_ADD,
    S_CAN_SHIFT
  } state_e;

endpackage

// File: src/dltq_if.sv
// Valid/ready channel interfaces for requests and results of the timer queue.
// Depends on nothing.
interface dltq_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] delay_ms;
  logic [3:0]  entry_id;
  modport source (output valid, req_type, delay_ms, entry_id, input ready);
  modport sink (input valid, req_type, delay_ms, entry_id, output ready);
endinterface

interface dltq_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [3:0] result_id;
  logic       expired;
  logic       last;
  modport source (output valid, status, result_id, expired, last, input ready);
  modport sink (input valid, status, result_id, expired, last, output ready);
endinterface

// File: src/dltq_cell.sv
// One slot of the sorted delta list: holds an id and its relative delay.
// Depends on dltq_pkg.
module dltq_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  dltq_pkg::cell_op_e             op_i,
  input  dltq_pkg::cell_t                left_i,
  input  dltq_pkg::cell_t                right_i,
  input  dltq_pkg::cell_t                load_i,
  input  logic [dltq_pkg::DeltaW-1:0]    arg_i,
  output dltq_pkg::cell_t                cur_o
);
  import dltq_pkg::*;

  cell_t cell_q, cell_d;

  always_comb begin
    cell_d = cell_q;
    unique case (op_i)
      OP_HOLD:       cell_d = cell_q;
      OP_SUB:        cell_d.delta = cell_q.delta - arg_i;
      OP_ADD:        cell_d.delta = cell_q.delta + arg_i;
      OP_LOAD:       cell_d = load_i;
      OP_TAKE_LEFT:  cell_d = left_i;
      OP_TAKE_RIGHT: cell_d = right_i;
      default:       cell_d = cell_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cur_o = cell_q;
endmodule

// File: src/delta_list_timer_queue_unit.sv
// Top level of the delta list timer queue: control sequencer, free id ring
// and a chain of dltq_cell slots. Depends on dltq_pkg, dltq_if and dltq_cell.
//
//   channel | direction | fields
//   req_i   | in        | req_type, delay_ms, entry_id
//   rsp_o   | out       | status, result_id, expired, last
//
// A schedule scans the list one slot per cycle, then shifts it and fixes up
// the successor delay. A tick pops the expired entries one by one. Reset
// empties the list and refills the free ring at once. A stalled result holds
// the sequencer until the result register can take the next result.
module delta_list_timer_queue_unit (
  input  logic clk_i,
  input  logic rst_ni,
  dltq_req_if.sink   req_i,
  dltq_rsp_if.source rsp_o
);
  import dltq_pkg::*;

  state_e            state_q, state_d;
  cell_t             cur   [ENTRIES];
  cell_op_e          op    [ENTRIES];
  cell_t             load;
  logic [DeltaW-1:0] arg;

  logic [IdW-1:0]    ring_q [ENTRIES];
  logic [IdW-1:0]    rptr_q, rptr_d, wptr_q, wptr_d;
  logic [PosW-1:0]   used_q, used_d;
  logic [ENTRIES-1:0] wait_q, wait_d;
  logic [PosW-1:0]   k_q, k_d;
  logic [DeltaW-1:0] rem_q, rem_d;
  logic [IdW-1:0]    nid_q, nid_d;

  logic              out_valid_q, out_valid_d;
  rsp_t              out_q, out_d;
  logic              emit_ok, accept, release_en;
  logic [IdW-1:0]    release_id;
  logic [PosW-1:0]   kp1, found_pos;
  cell_t             cur_k;

  assign emit_ok = !out_valid_q || rsp_o.ready;
  assign accept  = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE) && emit_ok;
  assign kp1 = k_q + 1'b1;
  assign cur_k = (k_q < PosW'(ENTRIES)) ? cur[k_q[IdW-1:0]] : '0;

  always_comb begin
    found_pos = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (cur[i].valid && cur[i].id == req_i.entry_id) found_pos = PosW'(i);
    end
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    cell_t left_n, right_n;
    if (g == 0) begin : g_first
      assign left_n = '0;
    end else begin : g_mid
      assign left_n = cur[g-1];
    end
    if (g == ENTRIES - 1) begin : g_last
      assign right_n = '0;
    end else begin : g_inner
      assign right_n = cur[g+1];
    end
    dltq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .op_i    (op[g]),
      .left_i  (left_n),
      .right_i (right_n),
      .load_i  (load),
      .arg_i   (arg),
      .cur_o   (cur[g])
    );
  end

  always_comb begin
    state_d     = state_q;
    rptr_d      = rptr_q;
    wptr_d      = wptr_q;
    used_d      = used_q;
    wait_d      = wait_q;
    k_d         = k_q;
    rem_d       = rem_q;
    nid_d       = nid_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_d       = out_q;
    release_en  = 1'b0;
    release_id  = '0;
    arg         = rem_q;
    load.valid  = 1'b1;
    load.id     = nid_q;
    load.delta  = rem_q;
    for (int i = 0; i < ENTRIES; i++) op[i] = OP_HOLD;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          priority case (req_i.req_type)
            REQ_SCHEDULE: begin
              out_valid_d = 1'b1;
              out_d = '{status: ST_ZERO_DELAY, id: '0, expired: 1'b0, last: 1'b1};
              if (req_i.delay_ms == '0) begin
                out_d.status = ST_ZERO_DELAY;
              end else if (used_q >= PosW'(ENTRIES)) begin
                out_d.status = ST_FULL;
              end else begin
                out_d.status = ST_OK;
                out_d.id     = ring_q[rptr_q];
                nid_d        = ring_q[rptr_q];
                rptr_d       = rptr_q + 1'b1;
                used_d       = used_q + 1'b1;
                wait_d[ring_q[rptr_q]] = 1'b1;
                rem_d        = req_i.delay_ms;
                k_d          = '0;
                state_d      = S_INS_SCAN;
              end
            end
            REQ_TICK: begin
              if (!cur[0].valid) begin
                out_valid_d = 1'b1;
                out_d = '{status: ST_NO_EXPIRY, id: '0, expired: 1'b0, last: 1'b1};
              end else begin
                arg     = DeltaW'(1);
                op[0]   = OP_SUB;
                state_d = S_TICK_CHK;
              end
            end
            REQ_CANCEL: begin
              out_valid_d = 1'b1;
              out_d = '{status: ST_OK, id: req_i.entry_id, expired: 1'b0, last: 1'b1};
              if ({1'b0, req_i.entry_id} >= (IdW+1)'(ENTRIES)) begin
                out_d.status = ST_BAD_ID;
              end else if (!wait_q[req_i.entry_id]) begin
                out_d.status = ST_NOT_WAITING;
              end else begin
                nid_d   = req_i.entry_id;
                k_d     = found_pos;
                state_d = S_CAN_ADD;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_INS_SCAN: begin
        if (cur_k.valid && rem_q >= cur_k.delta) begin
          rem_d = rem_q - cur_k.delta;
          k_d   = kp1;
        end else begin
          state_d = S_INS_SHIFT;
        end
      end
      S_INS_SHIFT: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (PosW'(i) == k_q) op[i] = OP_LOAD;
          else if (PosW'(i) > k_q) op[i] = OP_TAKE_LEFT;
        end
        state_d = S_INS_FIX;
      end
      S_INS_FIX: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (PosW'(i) == kp1 && cur[i].valid) op[i] = OP_SUB;
        end
        state_d = S_IDLE;
      end
      S_TICK_CHK: begin
        if (cur[0].delta != '0) begin
          if (emit_ok) begin
            out_valid_d = 1'b1;
            out_d = '{status: ST_NO_EXPIRY, id: '0, expired: 1'b0, last: 1'b1};
            state_d = S_IDLE;
          end
        end else begin
          state_d = S_TICK_POP;
        end
      end
      S_TICK_POP: begin
        if (emit_ok) begin
          out_valid_d = 1'b1;
          out_d.status  = ST_OK;
          out_d.id      = cur[0].id;
          out_d.expired = 1'b1;
          out_d.last    = !(cur[1].valid && cur[1].delta == '0);
          release_en    = 1'b1;
          release_id    = cur[0].id;
          for (int i = 0; i < ENTRIES; i++) op[i] = OP_TAKE_RIGHT;
          if (out_d.last) state_d = S_IDLE;
        end
      end
      S_CAN_ADD: begin
        arg = cur_k.delta;
        for (int i = 0; i < ENTRIES; i++) begin
          if (PosW'(i) == kp1 && cur[i].valid) op[i] = OP_ADD;
        end
        state_d = S_CAN_SHIFT;
      end
      S_CAN_SHIFT: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (PosW'(i) >= k_q) op[i] = OP_TAKE_RIGHT;
        end
        release_en = 1'b1;
        release_id = nid_q;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (release_en) begin
      wait_d[release_id] = 1'b0;
      wptr_d = wptr_q + 1'b1;
      if (used_q != '0) used_d = used_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rptr_q      <= '0;
      wptr_q      <= '0;
      used_q      <= '0;
      wait_q      <= '0;
      k_q         <= '0;
      rem_q       <= '0;
      nid_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      for (int i = 0; i < ENTRIES; i++) ring_q[i] <= IdW'(i);
    end else begin
      state_q     <= state_d;
      rptr_q      <= rptr_d;
      wptr_q      <= wptr_d;
      used_q      <= used_d;
      wait_q      <= wait_d;
      k_q         <= k_d;
      rem_q       <= rem_d;
      nid_q       <= nid_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
      if (release_en) ring_q[wptr_q] <= release_id;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.status    = out_q.status;
  assign rsp_o.result_id = out_q.id;
  assign rsp_o.expired   = out_q.expired;
  assign rsp_o.last      = out_q.last;
endmodule
